// ===== design/wrsi_pkg.sv =====
package wrsi_pkg;

  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int AVG_W      = PRICE_BITS + FRAC_BITS;
  localparam int PERIOD_W   = 11;
  localparam int RSI_W      = FRAC_BITS + 7;
  localparam int AVG_CNT_W  = $clog2(AVG_W);
  localparam int RSI_IDX_W  = $clog2(RSI_W);

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(14);
  localparam logic [RSI_W-1:0]    RSI_FULL   = RSI_W'(100) << FRAC_BITS;
  localparam logic [RSI_W-1:0]    RSI_HALF   = RSI_W'(50) << FRAC_BITS;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One price step handed from the front to the back.
  typedef struct packed {
    logic [PRICE_BITS-1:0] mag;
    logic                  up;
    logic                  down;
    logic                  twice;
    logic                  last;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_RATIO,
    BK_EMIT
  } back_state_t;

endpackage

// ===== design/wrsi_front.sv =====
module wrsi_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid_i,
  input  logic [wrsi_pkg::PRICE_BITS-1:0] in_close_price_i,
  input  logic                            in_last_sample_i,
  output logic                            in_stall_o,
  input  logic                            q_full_i,
  output logic                            push_o,
  output wrsi_pkg::cmd_t                  cmd_o
);

  logic [wrsi_pkg::PRICE_BITS-1:0] prev_r;
  logic [1:0]                      seen_r;
  logic                            accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // the first price of a series only primes the previous price
  assign push_o     = accept && (seen_r != 2'd0);

  always_comb begin
    cmd_o       = '0;
    cmd_o.up    = in_close_price_i > prev_r;
    cmd_o.down  = in_close_price_i < prev_r;
    cmd_o.mag   = cmd_o.up ? (in_close_price_i - prev_r) : (prev_r - in_close_price_i);
    cmd_o.twice = (seen_r == 2'd1);
    cmd_o.last  = in_last_sample_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      seen_r <= 2'd0;
    end else if (accept) begin
      if (in_last_sample_i) begin
        prev_r <= '0;
        seen_r <= 2'd0;
      end else begin
        prev_r <= in_close_price_i;
        seen_r <= (seen_r == 2'd0) ? 2'd1 : 2'd2;
      end
    end
  end

endmodule

// ===== design/wrsi_queue.sv =====
module wrsi_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  wrsi_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output wrsi_pkg::cmd_t cmd_o
);

  wrsi_pkg::cmd_t                    mem_r [wrsi_pkg::QUEUE_DEPTH];
  logic [wrsi_pkg::QUEUE_AW-1:0]     wr_ptr_r;
  logic [wrsi_pkg::QUEUE_AW-1:0]     rd_ptr_r;
  logic [wrsi_pkg::QUEUE_CW-1:0]     count_r;
  logic                              do_push;
  logic                              do_pop;

  assign full_o  = (count_r == wrsi_pkg::QUEUE_CW'(wrsi_pkg::QUEUE_DEPTH));
  assign valid_o = (count_r != '0);
  assign cmd_o   = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == wrsi_pkg::QUEUE_AW'(wrsi_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == wrsi_pkg::QUEUE_AW'(wrsi_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/wrsi_wilder.sv =====
module wrsi_wilder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [wrsi_pkg::AVG_W-1:0]    avg_i,
  input  logic [wrsi_pkg::AVG_W-1:0]    x_i,
  input  logic [wrsi_pkg::PERIOD_W-1:0] n_i,
  output logic                          done_o,
  output logic [wrsi_pkg::AVG_W-1:0]    avg_o
);

  logic [wrsi_pkg::AVG_W-1:0]     avg_r;
  logic [wrsi_pkg::AVG_W-1:0]     quo_r;
  logic [wrsi_pkg::PERIOD_W-1:0]  rem_r;
  logic [wrsi_pkg::PERIOD_W-1:0]  n_r;
  logic [wrsi_pkg::AVG_CNT_W-1:0] cnt_r;
  logic                           up_r;
  logic                           busy_r;
  logic                           done_r;

  logic [wrsi_pkg::PERIOD_W:0]    rem_sh;
  logic                           fits;
  logic [wrsi_pkg::PERIOD_W:0]    rem_sub;
  logic                           x_up;

  assign x_up    = x_i >= avg_i;
  // one restoring step: bring down the next dividend bit
  assign rem_sh  = {rem_r, quo_r[wrsi_pkg::AVG_W-1]};
  assign fits    = rem_sh >= {1'b0, n_r};
  assign rem_sub = rem_sh - {1'b0, n_r};

  // step toward x; a downward step rounds its magnitude up
  assign avg_o  = up_r ? (avg_r + quo_r)
                       : (avg_r - quo_r - wrsi_pkg::AVG_W'(rem_r != '0));
  assign done_o = done_r;

  always_ff @(posedge clk) begin
    if (start_i) begin
      avg_r <= avg_i;
      up_r  <= x_up;
      quo_r <= x_up ? (x_i - avg_i) : (avg_i - x_i);
      rem_r <= '0;
      n_r   <= n_i;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? rem_sub[wrsi_pkg::PERIOD_W-1:0] : rem_sh[wrsi_pkg::PERIOD_W-1:0];
      quo_r <= {quo_r[wrsi_pkg::AVG_W-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == wrsi_pkg::AVG_CNT_W'(wrsi_pkg::AVG_W - 1));
      if (start_i) begin
        busy_r <= 1'b1;
      end else if (cnt_r == wrsi_pkg::AVG_CNT_W'(wrsi_pkg::AVG_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

// ===== design/wrsi_back.sv =====
module wrsi_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid_i,
  input  logic [wrsi_pkg::PERIOD_W-1:0] cfg_period_i,
  output logic                          cfg_ready_o,
  input  logic                          q_valid_i,
  input  wrsi_pkg::cmd_t                q_cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wrsi_pkg::RSI_W-1:0]    out_rsi_value_o,
  output logic                          out_last_of_run_o
);

  localparam int SUM_W = wrsi_pkg::AVG_W + 1;
  localparam int R2_W  = wrsi_pkg::AVG_W + 3;

  wrsi_pkg::back_state_t          state_r;
  wrsi_pkg::back_state_t          state_nxt;
  wrsi_pkg::cmd_t                 cmd_r;
  logic [wrsi_pkg::PERIOD_W-1:0]  period_r;
  logic [wrsi_pkg::AVG_W-1:0]     avg_g_r;
  logic [wrsi_pkg::AVG_W-1:0]     avg_l_r;
  logic [SUM_W-1:0]               sum_r;
  logic [SUM_W-1:0]               rem_r;
  logic [wrsi_pkg::RSI_W-1:0]     quo_r;
  logic [wrsi_pkg::RSI_IDX_W-1:0] bidx_r;
  logic [wrsi_pkg::RSI_W-1:0]     rsi_r;
  logic                           twice_r;
  logic                           out_valid_r;
  logic [wrsi_pkg::RSI_W-1:0]     out_rsi_r;
  logic                           out_last_r;

  logic [wrsi_pkg::PERIOD_W-1:0]  n_eff;
  logic [wrsi_pkg::AVG_W-1:0]     x_g;
  logic [wrsi_pkg::AVG_W-1:0]     x_l;
  logic [wrsi_pkg::AVG_W-1:0]     g_res;
  logic [wrsi_pkg::AVG_W-1:0]     l_res;
  logic                           g_done;
  logic                           l_done;
  logic                           div_done;
  logic                           start_div;
  logic                           out_free;
  logic                           load_out;
  logic                           ratio_end;

  logic [R2_W-1:0]                r2;
  logic [R2_W-1:0]                s1;
  logic [R2_W-1:0]                s2;
  logic                           k1;
  logic                           k2;
  logic [R2_W-1:0]                r_left;
  logic [wrsi_pkg::RSI_W-1:0]     q_step;

  assign cfg_ready_o = 1'b1;
  assign n_eff       = (period_r == '0) ? wrsi_pkg::PERIOD_W'(1) : period_r;

  assign x_g = q_cmd_i.up   ? {q_cmd_i.mag, wrsi_pkg::FRAC_BITS'(0)} : '0;
  assign x_l = q_cmd_i.down ? {q_cmd_i.mag, wrsi_pkg::FRAC_BITS'(0)} : '0;

  wrsi_wilder u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start_div),
    .avg_i   (avg_g_r),
    .x_i     (x_g),
    .n_i     (n_eff),
    .done_o  (g_done),
    .avg_o   (g_res)
  );

  wrsi_wilder u_loss (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start_div),
    .avg_i   (avg_l_r),
    .x_i     (x_l),
    .n_i     (n_eff),
    .done_o  (l_done),
    .avg_o   (l_res)
  );

  assign div_done  = g_done && l_done;
  assign out_free  = !out_valid_r || !out_stall_i;
  assign ratio_end = (bidx_r == '0);

  // ratio step: r = 2r + bit*g, then take off 0, 1 or 2 times the sum
  assign r2     = {1'b0, rem_r, 1'b0}
                + (wrsi_pkg::RSI_FULL[bidx_r] ? R2_W'(avg_g_r) : '0);
  assign s1     = R2_W'(sum_r);
  assign s2     = {1'b0, sum_r, 1'b0};
  assign k2     = r2 >= s2;
  assign k1     = r2 >= s1;
  assign r_left = k2 ? (r2 - s2) : (k1 ? (r2 - s1) : r2);
  assign q_step = {quo_r[wrsi_pkg::RSI_W-2:0], 1'b0}
                + (k2 ? wrsi_pkg::RSI_W'(2) : (k1 ? wrsi_pkg::RSI_W'(1) : '0));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wrsi_pkg::BK_IDLE:  if (q_valid_i) state_nxt = wrsi_pkg::BK_DIV;
      wrsi_pkg::BK_DIV: begin
        if (div_done) begin
          state_nxt = (l_res == '0) ? wrsi_pkg::BK_EMIT : wrsi_pkg::BK_RATIO;
        end
      end
      wrsi_pkg::BK_RATIO: if (ratio_end) state_nxt = wrsi_pkg::BK_EMIT;
      wrsi_pkg::BK_EMIT:  if (out_free && !twice_r) state_nxt = wrsi_pkg::BK_IDLE;
      default:            state_nxt = wrsi_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o   = 1'b0;
    start_div = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      wrsi_pkg::BK_IDLE: begin
        q_pop_o   = q_valid_i;
        start_div = q_valid_i;
      end
      wrsi_pkg::BK_EMIT: load_out = out_free;
      default: begin
        q_pop_o   = 1'b0;
        start_div = 1'b0;
        load_out  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrsi_pkg::BK_IDLE;
      period_r    <= wrsi_pkg::PERIOD_RST;
      avg_g_r     <= '0;
      avg_l_r     <= '0;
      twice_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid_i) begin
        period_r <= cfg_period_i;
      end
      if (state_r == wrsi_pkg::BK_IDLE && q_valid_i) begin
        twice_r <= q_cmd_i.twice;
      end
      if (state_r == wrsi_pkg::BK_DIV && div_done) begin
        avg_g_r <= g_res;
        avg_l_r <= l_res;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
        twice_r     <= 1'b0;
        // drop the averages once the series is done
        if (!twice_r && cmd_r.last) begin
          avg_g_r <= '0;
          avg_l_r <= '0;
        end
      end else if (!out_stall_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == wrsi_pkg::BK_IDLE && q_valid_i) begin
      cmd_r <= q_cmd_i;
    end
    if (state_r == wrsi_pkg::BK_DIV && div_done) begin
      sum_r  <= {1'b0, g_res} + {1'b0, l_res};
      rem_r  <= '0;
      quo_r  <= '0;
      bidx_r <= wrsi_pkg::RSI_IDX_W'(wrsi_pkg::RSI_W - 1);
      rsi_r  <= (g_res == '0) ? wrsi_pkg::RSI_HALF : wrsi_pkg::RSI_FULL;
    end
    if (state_r == wrsi_pkg::BK_RATIO) begin
      rem_r  <= r_left[SUM_W-1:0];
      quo_r  <= q_step;
      bidx_r <= bidx_r - 1'b1;
      if (ratio_end) begin
        rsi_r <= q_step;
      end
    end
    if (load_out) begin
      out_rsi_r  <= rsi_r;
      out_last_r <= twice_r ? 1'b0 : cmd_r.last;
    end
  end

  assign out_valid_o       = out_valid_r;
  assign out_rsi_value_o   = out_rsi_r;
  assign out_last_of_run_o = out_last_r;

endmodule

// ===== design/wilder_rsi_stream_top.sv =====
// Path from an accepted price to its first result: the queue, the two average dividers side by
// side, a hand-over, the RSI ratio and the output register; the ratio is skipped when the loss
// average is zero. The back end takes a new price from the queue only once it has emitted the
// result of the last one (the second price of a series emits its result twice), and output
// stalls hold it; a first price only primes, and the two-entry queue buffers prices.
// Reset (rst_n low, synchronous) clears queue, averages, series position, output valid; period 14.
module wilder_rsi_stream_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [wrsi_pkg::PRICE_BITS-1:0] in_close_price,
  input  logic                            in_last_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wrsi_pkg::RSI_W-1:0]      out_rsi_value,
  output logic                            out_last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wrsi_pkg::PERIOD_W-1:0]   cfg_period
);

  wrsi_pkg::cmd_t push_cmd;
  wrsi_pkg::cmd_t head_cmd;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;

  wrsi_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid_i       (in_valid),
    .in_close_price_i (in_close_price),
    .in_last_sample_i (in_last_sample),
    .in_stall_o       (in_stall),
    .q_full_i         (q_full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  wrsi_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  wrsi_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_period_i      (cfg_period),
    .cfg_ready_o       (cfg_ready),
    .q_valid_i         (q_valid),
    .q_cmd_i           (head_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_rsi_value_o   (out_rsi_value),
    .out_last_of_run_o (out_last_of_run)
  );

endmodule

// ===== design/wrsi_checker.sv =====
module wrsi_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [wrsi_pkg::RSI_W-1:0]    out_rsi_value,
  input logic                          out_last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsi_value) && $stable(out_last_of_run))
    else $error("stalled result changed");

  // RSI never exceeds 100
  a_rsi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsi_value <= wrsi_pkg::RSI_FULL)
    else $error("rsi above full scale");

  // reset empties the queue and the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("reset did not clear valid or stall");

endmodule

bind wilder_rsi_stream_top wrsi_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_rsi_value   (out_rsi_value),
  .out_last_of_run (out_last_of_run)
);
